/* design/kpud_pkg.sv */
// Package for the key long-press up/down counter.
// Holds the phase and register index codes, reset values and the digit/segment helpers.
// No dependencies.
package kpud_pkg;

    // Press tracking phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2,
        PH_REPEAT   = 2'd3
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_REPEAT   = 2'd2,
        CFG_MAX      = 2'd3
    } cfg_idx_t;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned ValueW   = 7;
    localparam int unsigned SegW     = 7;

    localparam logic [3:0]        DebounceRst = 4'd1;
    localparam logic [7:0]        LongRst     = 8'd200;
    localparam logic [3:0]        RepeatRst   = 4'd5;
    localparam logic [ValueW-1:0] MaxRst      = 7'd99;
    localparam logic [ValueW-1:0] ValueCap    = 7'd99;
    localparam logic [7:0]        HoldSat     = 8'd255;

    // Live configuration
    typedef struct packed {
        logic [3:0]        debounce_ticks;
        logic [7:0]        long_press_ticks;
        logic [3:0]        repeat_ticks;
        logic [ValueW-1:0] max_value;
    } cfg_t;

    // Tens and ones digits of a 7-bit value (tens taken modulo 10)
    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    // Divide by 10 through reciprocal multiply: exact for every 7-bit value (0 to 127)
    function automatic digits_t split_digits(input logic [ValueW-1:0] v);
        logic [14:0]       prod;
        logic [3:0]        q;
        logic [ValueW-1:0] rem;
        digits_t           d;
        prod   = {8'd0, v} * 15'd205;
        q      = prod[14:11];
        rem    = v - ValueW'({q, 3'd0} + {2'd0, q, 1'b0});
        d.ones = rem[3:0];
        d.tens = (q >= 4'd10) ? (q - 4'd10) : q;
        return d;
    endfunction

    // Seven-segment code, bit0 = segment a
    function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
        logic [SegW-1:0] s;
        unique case (digit)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

/* design/kpud_key_if.sv */
// Key sample request channel: one sample of both keys per request.
// No dependencies.
interface kpud_key_if;
    logic valid;
    logic ready;
    logic up_pressed;
    logic down_pressed;

    modport source (output valid, output up_pressed, output down_pressed, input ready);
    modport sink   (input valid, input up_pressed, input down_pressed, output ready);
endinterface

/* design/kpud_result_if.sv */
// Result request channel: counted value and its two seven-segment codes.
// No dependencies.
interface kpud_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] value;
    logic [6:0] tens_segments;
    logic [6:0] ones_segments;

    modport source (output valid, output value, output tens_segments,
                    output ones_segments, input ready);
    modport sink   (input valid, input value, input tens_segments,
                    input ones_segments, output ready);
endinterface

/* design/kpud_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on kpud_pkg.
interface kpud_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kpud_pkg::CfgIdxW-1:0]   index;
    logic [kpud_pkg::CfgDataW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/key_long_press_updown_counter.sv */
// Top level of the key long-press up/down counter.
// Depends on kpud_pkg, the three channel interfaces, kpud_cfg, kpud_ctrl and kpud_out.
//
// Usage:
//   keys   : one request per 10 ms tick with the up and down key levels (1 = pressed).
//   result : one request per key request with the counted value and the
//            seven-segment codes of its tens and ones digits.
//   cfg    : register writes (0 debounce, 1 long press, 2 repeat, 3 maximum);
//            always ready, write only while no sample is in flight.
// Latency: a result is valid the cycle after its key request is accepted.
// Throughput: one key request per cycle while keys.ready is high; the state update and
//   digit encode sit between the state registers and the single result register.
// Stall: while the result register is full and not taken, keys.ready is low;
//   it rises again in the cycle the receiver takes the result.
// Reset: rst_n (async, active low) empties the result register, returns the
//   press tracker to idle with value 0 and loads the register defaults
//   (debounce 1, long press 200, repeat 5, maximum 99).
module key_long_press_updown_counter (
    input  logic            clk,
    input  logic            rst_n,
    kpud_key_if.sink        keys,
    kpud_result_if.source   result,
    kpud_cfg_if.sink        cfg
);

    kpud_pkg::cfg_t                 cfg_live;
    logic                           room;
    logic                           take;
    logic [kpud_pkg::ValueW-1:0]    value_next;

    assign keys.ready = room;
    assign take       = keys.valid && room;

    kpud_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_live)
    );

    kpud_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .up_pressed   (keys.up_pressed),
        .down_pressed (keys.down_pressed),
        .cfg          (cfg_live),
        .value_next   (value_next)
    );

    kpud_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .value_next (value_next),
        .room       (room),
        .result     (result)
    );

endmodule

/* design/kpud_cfg.sv */
// Configuration register bank for the key counter.
// Depends on kpud_pkg and kpud_cfg_if.
module kpud_cfg (
    input  logic                clk,
    input  logic                rst_n,
    kpud_cfg_if.sink            cfg,
    output kpud_pkg::cfg_t      cfg_out
);

    kpud_pkg::cfg_t cfg_reg;
    kpud_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (kpud_pkg::cfg_idx_t'(cfg.index))
                kpud_pkg::CFG_DEBOUNCE: cfg_next.debounce_ticks   = cfg.data[3:0];
                kpud_pkg::CFG_LONG:     cfg_next.long_press_ticks = cfg.data;
                kpud_pkg::CFG_REPEAT:   cfg_next.repeat_ticks     = cfg.data[3:0];
                kpud_pkg::CFG_MAX:      cfg_next.max_value        = cfg.data[6:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= kpud_pkg::DebounceRst;
            cfg_reg.long_press_ticks <= kpud_pkg::LongRst;
            cfg_reg.repeat_ticks     <= kpud_pkg::RepeatRst;
            cfg_reg.max_value        <= kpud_pkg::MaxRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/kpud_ctrl.sv */
// Press tracking and counter update: one state update per accepted key sample.
// Depends on kpud_pkg.
module kpud_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic                              up_pressed,
    input  logic                              down_pressed,
    input  kpud_pkg::cfg_t                    cfg,
    output logic [kpud_pkg::ValueW-1:0]       value_next
);

    kpud_pkg::phase_t                  phase_reg, phase_next;
    logic                              down_reg, down_next;
    logic [7:0]                        hold_reg, hold_next;
    logic [3:0]                        rpt_reg, rpt_next;
    logic [kpud_pkg::ValueW-1:0]       count_reg, count_next;

    logic                              key;
    logic [3:0]                        rpt_inc;
    logic [7:0]                        hold_inc;
    logic                              deb_done;
    logic                              long_done;
    logic                              rpt_done;
    logic                              do_step;
    logic [kpud_pkg::ValueW-1:0]       lim;

    // Level of the key that owns the press
    assign key       = down_reg ? down_pressed : up_pressed;
    assign rpt_inc   = rpt_reg + 4'd1;
    assign hold_inc  = (hold_reg == kpud_pkg::HoldSat) ? hold_reg : hold_reg + 8'd1;
    assign deb_done  = (rpt_inc >= cfg.debounce_ticks);
    assign long_done = (hold_inc >= cfg.long_press_ticks);
    assign rpt_done  = (rpt_inc >= cfg.repeat_ticks);
    assign lim       = (cfg.max_value > kpud_pkg::ValueCap) ? kpud_pkg::ValueCap
                                                           : cfg.max_value;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            kpud_pkg::PH_IDLE:
                if (up_pressed || down_pressed)
                    phase_next = kpud_pkg::PH_DEBOUNCE;
            kpud_pkg::PH_DEBOUNCE:
                if (deb_done)
                    phase_next = key ? kpud_pkg::PH_HELD : kpud_pkg::PH_IDLE;
            kpud_pkg::PH_HELD:
                if (!key)
                    phase_next = kpud_pkg::PH_IDLE;
                else if (long_done)
                    phase_next = kpud_pkg::PH_REPEAT;
            kpud_pkg::PH_REPEAT:
                if (!key)
                    phase_next = kpud_pkg::PH_IDLE;
            default:
                phase_next = kpud_pkg::PH_IDLE;
        endcase
    end

    // Counters and step request
    always_comb
    begin
        down_next = down_reg;
        hold_next = hold_reg;
        rpt_next  = rpt_reg;
        do_step   = 1'b0;
        unique case (phase_reg)
            kpud_pkg::PH_IDLE:
                if (up_pressed || down_pressed)
                begin
                    down_next = !up_pressed;
                    hold_next = 8'd0;
                    rpt_next  = 4'd0;
                end
            kpud_pkg::PH_DEBOUNCE:
            begin
                rpt_next = rpt_inc;
                if (deb_done)
                begin
                    rpt_next  = 4'd0;
                    hold_next = 8'd0;
                end
            end
            kpud_pkg::PH_HELD:
                if (!key)
                begin
                    do_step   = 1'b1;
                    hold_next = 8'd0;
                    rpt_next  = 4'd0;
                end
                else if (long_done)
                begin
                    do_step   = 1'b1;
                    hold_next = 8'd0;
                    rpt_next  = 4'd0;
                end
                else
                    hold_next = hold_inc;
            kpud_pkg::PH_REPEAT:
                if (!key)
                begin
                    do_step   = 1'b1;
                    hold_next = 8'd0;
                    rpt_next  = 4'd0;
                end
                else if (rpt_done)
                begin
                    do_step  = 1'b1;
                    rpt_next = 4'd0;
                end
                else
                    rpt_next = rpt_inc;
            default:
                do_step = 1'b0;
        endcase
    end

    // Saturating step
    always_comb
    begin
        count_next = count_reg;
        if (do_step)
        begin
            if (down_reg)
            begin
                if (count_reg != '0)
                    count_next = count_reg - 7'd1;
            end
            else if (count_reg < lim)
                count_next = count_reg + 7'd1;
        end
    end

    assign value_next = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kpud_pkg::PH_IDLE;
            down_reg  <= 1'b0;
            hold_reg  <= 8'd0;
            rpt_reg   <= 4'd0;
            count_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            down_reg  <= down_next;
            hold_reg  <= hold_next;
            rpt_reg   <= rpt_next;
            count_reg <= count_next;
        end
    end

    // Value never leaves the two-digit range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kpud_pkg::ValueCap)
        else $error("count above 99");

    // State only moves on an accepted sample
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(count_reg) && $stable(phase_reg))
        else $error("state changed without a request");

    // Hold counter is only in use while held
    a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != kpud_pkg::PH_HELD |-> hold_reg == 8'd0)
        else $error("hold count outside held phase");

    // One step at most per sample
    a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (count_reg == $past(count_reg))
              || (count_reg == $past(count_reg) + 7'd1)
              || (count_reg == $past(count_reg) - 7'd1))
        else $error("value moved by more than one");

endmodule

/* design/kpud_out.sv */
// Result register: digit split, segment encode and output valid.
// Depends on kpud_pkg and kpud_result_if.
module kpud_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [kpud_pkg::ValueW-1:0]      value_next,
    output logic                             room,
    kpud_result_if.source                    result
);

    logic                            valid_reg;
    logic [kpud_pkg::ValueW-1:0]     value_reg;
    logic [kpud_pkg::SegW-1:0]       tens_reg;
    logic [kpud_pkg::SegW-1:0]       ones_reg;
    kpud_pkg::digits_t               dig;

    // Register can load when empty or being drained
    assign room = !valid_reg || result.ready;
    assign dig  = kpud_pkg::split_digits(value_next);

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (room)
            valid_reg <= take;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= value_next;
            tens_reg  <= kpud_pkg::seg_code(dig.tens);
            ones_reg  <= kpud_pkg::seg_code(dig.ones);
        end
    end

    assign result.valid         = valid_reg;
    assign result.value         = value_reg;
    assign result.tens_segments = tens_reg;
    assign result.ones_segments = ones_reg;

endmodule
